// ----- hw/rtl/tmp_pkg.sv -----
// tmp_pkg: types, codes and helper functions for the trapezoid motion profile block
// used by trapezoid_motion_profile_top; no dependencies
`timescale 1ns / 1ps

package tmp_pkg;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DA,
		S_VV,
		S_VVA,
		S_SQRT,
		S_RAMP,
		S_CRUISE,
		S_CNT,
		S_TT,
		S_TR,
		S_M1,
		S_M2,
		S_M3,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef enum logic [1:0] {
		PH_ACCEL,
		PH_CRUISE,
		PH_DECEL
	} phase_t;

	localparam logic       CMD_START = 1'b0;
	localparam logic [1:0] REG_TICK  = 2'd0;
	localparam logic [1:0] REG_VEL   = 2'd1;
	localparam logic [1:0] REG_ACC   = 2'd2;

	localparam logic [31:0] TICK_RESET = 32'd16777;
	localparam logic [30:0] VEL_RESET  = 31'd6553600;
	localparam logic [30:0] ACC_RESET  = 31'd65536000;

	localparam logic [62:0] CAP62 = 63'h4000_0000_0000_0000;
	localparam logic [6:0]  STEPS_WIDE = 7'd64;
	localparam logic [6:0]  STEPS_ROOT = 7'd32;

	// truncated product floor(p / 2^24 or 2^25), capped at 2^62
	function automatic logic [62:0] mul_cap(input logic [127:0] p, input logic sh25);
		logic [127:0] s;
		s = sh25 ? (p >> 25) : (p >> 24);
		return (s > {65'd0, CAP62}) ? CAP62 : s[62:0];
	endfunction

	function automatic logic [31:0] sat_u32(input logic [63:0] x);
		return (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic [31:0] sat_s32(input logic signed [64:0] x);
		logic [31:0] r;
		if (x > 65'sh0_7FFF_FFFF)
			r = 32'h7FFF_FFFF;
		else if (x < -65'sh0_8000_0000)
			r = 32'h8000_0000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/trapezoid_motion_profile_top.sv -----
// trapezoid_motion_profile_top: trapezoidal velocity profile generator, one module
// depends on tmp_pkg
`timescale 1ns / 1ps

// A start word plans a move with the configured speed, acceleration and sample period;
// each later tick word yields one setpoint (position, velocity), the final one being the
// end position at zero velocity with last_point set. Ticks while idle give no result.
// All arithmetic runs through one shared unit that retires one bit per cycle: a 64-step
// shift-add multiplier, a 64-step restoring divider, or a 32-step square root, each
// loaded with its operands first. A start takes 2 multiplies and 4 divides (trapezoid)
// or 2 multiplies, 1 root and 2 divides (triangle); a tick takes 3 to 5 multiplies,
// and a final point takes none but may wait while the previous result word is held.
// in_ready is high only between items.
// Configuration registers: 0 tick_period, 1 vel_limit, 2 acc_limit; a zero acts as one.
module trapezoid_motion_profile_top #(
	parameter int MAX_POINTS = 16777215
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [31:0] start_pos,
	input  logic signed [31:0] end_pos,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity,
	output logic               last_point
);

	localparam logic [23:0] MAX_PTS = 24'(MAX_POINTS);

	tmp_pkg::state_t state_q, state_d;

	logic [31:0] tick_q;
	logic [30:0] vel_lim_q, acc_lim_q;
	logic [31:0] dt_eff;
	logic [30:0] v_eff, a_eff;

	logic               active_q, tri_q, dir_neg_q, fin_q;
	logic [23:0]        idx_q, total_q;
	logic signed [31:0] origin_q, target_q;
	logic [31:0]        ramp_q, cruise_q, peak_q;
	logic [32:0]        dist_q, cd_q;
	logic [63:0]        da_q, vv_q, t_q, mag_q;
	logic [62:0]        r_q, vel_q;
	tmp_pkg::phase_t    phase_q;

	// shared unit
	logic [127:0]   work_q, work_step;
	logic [63:0]    x_q, x_step;
	logic [6:0]     cnt_q;
	logic           run_q;
	tmp_pkg::op_t   op_q, op_sel;
	logic [63:0]    ld_x, ld_y;
	logic           unit_state, unit_done, sh25;
	logic [62:0]    mres;

	logic           in_acc, out_write;
	logic [63:0]    t_minus_ta, td;
	logic signed [32:0] diff;
	logic signed [64:0] pos_full, vel_full;
	logic [62:0]    mag_c;

	assign dt_eff = (tick_q == 32'd0) ? 32'd1 : tick_q;
	assign v_eff  = (vel_lim_q == 31'd0) ? 31'd1 : vel_lim_q;
	assign a_eff  = (acc_lim_q == 31'd0) ? 31'd1 : acc_lim_q;

	assign in_acc     = in_valid && in_ready;
	assign diff       = 33'(end_pos) - 33'(start_pos);
	assign t_minus_ta = t_q - {32'd0, ramp_q};
	assign td         = t_q - {32'd0, ramp_q} - {32'd0, cruise_q};
	assign unit_done  = run_q && (cnt_q == 7'd0);
	assign mres       = tmp_pkg::mul_cap(work_q, sh25);

	// unit step
	always_comb begin
		logic [64:0] add;
		logic [32:0] tr;
		logic [32:0] rem;
		logic        ge;
		logic [63:0] s;
		work_step = work_q;
		x_step    = x_q;
		add = 65'd0;
		tr  = 33'd0;
		rem = 33'd0;
		ge  = 1'b0;
		s   = 64'd0;
		case (op_q)
			tmp_pkg::OP_MUL: begin
				add = {1'b0, work_q[127:64]} + (work_q[0] ? {1'b0, x_q} : 65'd0);
				work_step = {add, work_q[63:1]};
			end
			tmp_pkg::OP_DIV: begin
				tr  = {work_q[95:64], work_q[63]};
				ge  = tr >= {1'b0, x_q[31:0]};
				rem = ge ? (tr - {1'b0, x_q[31:0]}) : tr;
				work_step = {31'd0, rem, work_q[62:0], ge};
			end
			tmp_pkg::OP_SQRT: begin
				s  = work_q[63:0] + x_q;
				ge = work_q[127:64] >= s;
				work_step = ge ? {work_q[127:64] - s, (work_q[63:0] >> 1) + x_q}
				               : {work_q[127:64], work_q[63:0] >> 1};
				x_step = x_q >> 2;
			end
			default: begin
				work_step = work_q;
			end
		endcase
	end

	// operand selection for the unit and result shift
	always_comb begin
		op_sel = tmp_pkg::OP_MUL;
		ld_x   = 64'd0;
		ld_y   = 64'd0;
		sh25   = 1'b0;
		unique case (state_q)
			tmp_pkg::S_DA: begin
				ld_x = {31'd0, dist_q};
				ld_y = {33'd0, a_eff};
			end
			tmp_pkg::S_VV: begin
				ld_x = {33'd0, v_eff};
				ld_y = {33'd0, v_eff};
			end
			tmp_pkg::S_VVA: begin
				op_sel = tmp_pkg::OP_DIV;
				ld_x   = {33'd0, a_eff};
				ld_y   = vv_q;
			end
			tmp_pkg::S_SQRT: begin
				op_sel = tmp_pkg::OP_SQRT;
				ld_x   = 64'h4000_0000_0000_0000;
				ld_y   = da_q;
			end
			tmp_pkg::S_RAMP: begin
				op_sel = tmp_pkg::OP_DIV;
				ld_x   = {33'd0, a_eff};
				ld_y   = {8'd0, peak_q, 24'd0};
			end
			tmp_pkg::S_CRUISE: begin
				op_sel = tmp_pkg::OP_DIV;
				ld_x   = {33'd0, v_eff};
				ld_y   = {7'd0, cd_q, 24'd0};
			end
			tmp_pkg::S_CNT: begin
				op_sel = tmp_pkg::OP_DIV;
				ld_x   = {32'd0, dt_eff};
				ld_y   = 64'({32'd0, cruise_q}) + {31'd0, ramp_q, 1'b0};
			end
			tmp_pkg::S_TT: begin
				ld_x = {40'd0, idx_q};
				ld_y = {32'd0, dt_eff};
			end
			tmp_pkg::S_TR: begin
				ld_x = {32'd0, peak_q};
				ld_y = {32'd0, ramp_q};
				sh25 = 1'b1;
			end
			tmp_pkg::S_M1: begin
				case (phase_q)
					tmp_pkg::PH_ACCEL: begin
						ld_x = {33'd0, a_eff};
						ld_y = t_q;
					end
					tmp_pkg::PH_CRUISE: begin
						ld_x = {32'd0, peak_q};
						ld_y = t_minus_ta;
					end
					default: begin
						ld_x = {33'd0, a_eff};
						ld_y = td;
					end
				endcase
			end
			tmp_pkg::S_M2: begin
				if (phase_q == tmp_pkg::PH_ACCEL) begin
					ld_x = {1'b0, vel_q};
					ld_y = t_q;
					sh25 = 1'b1;
				end else begin
					ld_x = {32'd0, peak_q};
					ld_y = {32'd0, cruise_q};
				end
			end
			tmp_pkg::S_M3: begin
				ld_x = {1'b0, vel_q} + {32'd0, peak_q};
				ld_y = td;
				sh25 = 1'b1;
			end
			default: begin
				ld_x = 64'd0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmp_pkg::S_IDLE: begin
				if (in_acc) begin
					if (command == tmp_pkg::CMD_START)
						state_d = tmp_pkg::S_DA;
					else if (active_q)
						state_d = (idx_q >= total_q) ? tmp_pkg::S_OUT : tmp_pkg::S_TT;
				end
			end
			tmp_pkg::S_DA:     if (unit_done) state_d = tmp_pkg::S_VV;
			tmp_pkg::S_VV: begin
				if (unit_done)
					state_d = (da_q > work_q[63:0]) ? tmp_pkg::S_VVA : tmp_pkg::S_SQRT;
			end
			tmp_pkg::S_VVA:    if (unit_done) state_d = tmp_pkg::S_RAMP;
			tmp_pkg::S_SQRT:   if (unit_done) state_d = tmp_pkg::S_RAMP;
			tmp_pkg::S_RAMP: begin
				if (unit_done)
					state_d = tri_q ? tmp_pkg::S_CNT : tmp_pkg::S_CRUISE;
			end
			tmp_pkg::S_CRUISE: if (unit_done) state_d = tmp_pkg::S_CNT;
			tmp_pkg::S_CNT:    if (unit_done) state_d = tmp_pkg::S_IDLE;
			tmp_pkg::S_TT:     if (unit_done) state_d = tmp_pkg::S_TR;
			tmp_pkg::S_TR:     if (unit_done) state_d = tmp_pkg::S_M1;
			tmp_pkg::S_M1: begin
				if (unit_done)
					state_d = (phase_q == tmp_pkg::PH_CRUISE) ? tmp_pkg::S_OUT : tmp_pkg::S_M2;
			end
			tmp_pkg::S_M2: begin
				if (unit_done)
					state_d = (phase_q == tmp_pkg::PH_ACCEL) ? tmp_pkg::S_OUT : tmp_pkg::S_M3;
			end
			tmp_pkg::S_M3:     if (unit_done) state_d = tmp_pkg::S_OUT;
			tmp_pkg::S_OUT:    if (out_write) state_d = tmp_pkg::S_IDLE;
			default:           state_d = tmp_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready   = 1'b0;
		out_write  = 1'b0;
		unit_state = 1'b0;
		unique case (state_q)
			tmp_pkg::S_IDLE: in_ready = 1'b1;
			tmp_pkg::S_OUT:  out_write = !out_valid || out_ready;
			default:         unit_state = 1'b1;
		endcase
	end

	assign cfg_ready = 1'b1;

	// output shaping for a normal setpoint
	assign mag_c    = (mag_q > {1'b0, tmp_pkg::CAP62}) ? tmp_pkg::CAP62 : mag_q[62:0];
	assign pos_full = dir_neg_q ? (65'(origin_q) - $signed({2'b00, mag_c}))
	                            : (65'(origin_q) + $signed({2'b00, mag_c}));
	assign vel_full = dir_neg_q ? -$signed({2'b00, vel_q}) : $signed({2'b00, vel_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tmp_pkg::S_IDLE;
			tick_q    <= tmp_pkg::TICK_RESET;
			vel_lim_q <= tmp_pkg::VEL_RESET;
			acc_lim_q <= tmp_pkg::ACC_RESET;
			active_q  <= 1'b0;
			idx_q     <= 24'd0;
			total_q   <= 24'd0;
			origin_q  <= 32'sd0;
			target_q  <= 32'sd0;
			dir_neg_q <= 1'b0;
			ramp_q    <= 32'd0;
			cruise_q  <= 32'd0;
			peak_q    <= 32'd0;
			tri_q     <= 1'b0;
			run_q     <= 1'b0;
			cnt_q     <= 7'd0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tmp_pkg::REG_TICK: tick_q    <= cfg_data;
					tmp_pkg::REG_VEL:  vel_lim_q <= cfg_data[30:0];
					tmp_pkg::REG_ACC:  acc_lim_q <= cfg_data[30:0];
					default: ;
				endcase
			end

			// unit sequencing
			if (unit_state && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= (op_sel == tmp_pkg::OP_SQRT) ? tmp_pkg::STEPS_ROOT : tmp_pkg::STEPS_WIDE;
			end else if (unit_done) begin
				run_q <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
			end

			if (in_acc && command == tmp_pkg::CMD_START) begin
				origin_q  <= start_pos;
				target_q  <= end_pos;
				dir_neg_q <= diff[32];
			end

			if (unit_done) begin
				case (state_q)
					tmp_pkg::S_VV: begin
						if (da_q > work_q[63:0]) begin
							tri_q  <= 1'b0;
							peak_q <= {1'b0, v_eff};
						end else begin
							tri_q    <= 1'b1;
							cruise_q <= 32'd0;
						end
					end
					tmp_pkg::S_SQRT:   peak_q   <= work_q[31:0];
					tmp_pkg::S_RAMP:   ramp_q   <= tmp_pkg::sat_u32(work_q[63:0]);
					tmp_pkg::S_CRUISE: cruise_q <= tmp_pkg::sat_u32(work_q[63:0]);
					tmp_pkg::S_CNT: begin
						total_q  <= (work_q[63:0] > {40'd0, MAX_PTS}) ? MAX_PTS
						                                              : work_q[23:0];
						idx_q    <= 24'd0;
						active_q <= 1'b1;
					end
					default: ;
				endcase
			end

			if (out_write) begin
				out_valid <= 1'b1;
				if (fin_q) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 24'd1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (unit_state && !run_q) begin
			op_q   <= op_sel;
			x_q    <= ld_x;
			work_q <= (op_sel == tmp_pkg::OP_SQRT) ? {ld_y, 64'd0} : {64'd0, ld_y};
		end else if (run_q && !unit_done) begin
			work_q <= work_step;
			x_q    <= x_step;
		end

		if (in_acc) begin
			fin_q  <= (idx_q >= total_q);
			dist_q <= diff[32] ? 33'(-diff) : 33'(diff);
		end

		if (unit_done) begin
			case (state_q)
				tmp_pkg::S_DA:  da_q <= work_q[63:0];
				tmp_pkg::S_VV:  vv_q <= work_q[63:0];
				tmp_pkg::S_VVA: cd_q <= dist_q - work_q[32:0];
				tmp_pkg::S_TT:  t_q  <= work_q[63:0];
				tmp_pkg::S_TR: begin
					r_q <= mres;
					if (t_q <= {32'd0, ramp_q})
						phase_q <= tmp_pkg::PH_ACCEL;
					else if (!tri_q && t_q <= 64'({32'd0, ramp_q}) + {32'd0, cruise_q})
						phase_q <= tmp_pkg::PH_CRUISE;
					else
						phase_q <= tmp_pkg::PH_DECEL;
				end
				tmp_pkg::S_M1: begin
					case (phase_q)
						tmp_pkg::PH_ACCEL: vel_q <= mres;
						tmp_pkg::PH_CRUISE: begin
							vel_q <= {31'd0, peak_q};
							mag_q <= {1'b0, r_q} + {1'b0, mres};
						end
						default: begin
							vel_q <= ({31'd0, peak_q} > mres) ? ({31'd0, peak_q} - mres) : 63'd0;
						end
					endcase
				end
				tmp_pkg::S_M2: begin
					if (phase_q == tmp_pkg::PH_ACCEL)
						mag_q <= {1'b0, mres};
					else
						mag_q <= {1'b0, r_q} + {1'b0, mres};
				end
				tmp_pkg::S_M3: mag_q <= mag_q + {1'b0, mres};
				default: ;
			endcase
		end

		if (out_write) begin
			if (fin_q) begin
				position   <= target_q;
				velocity   <= 32'sd0;
				last_point <= 1'b1;
			end else begin
				position   <= tmp_pkg::sat_s32(pos_full);
				velocity   <= tmp_pkg::sat_s32(vel_full);
				last_point <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// a result word is only ever produced from the output state
	a_out_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == tmp_pkg::S_OUT))
		else $error("result word appeared outside the output state");

	// the final point carries zero velocity
	a_last_point_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_point) |-> (velocity == 32'sd0))
		else $error("final point with wrong value");

	// a planned move never runs past its final point
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && state_q == tmp_pkg::S_IDLE) |-> (idx_q <= total_q))
		else $error("sample index past point count");
`endif

endmodule
